/* sv/rbwp_pkg.sv */
`default_nettype none
package rbwp_pkg;

   localparam int unsigned DEF_MEM_WORDS = 1024;

   localparam int unsigned OFF_W   = 12;
   localparam int unsigned SIZE_W  = 13;
   localparam int unsigned PADDR_W = 4;
   localparam int unsigned PDATA_W = 32;

   typedef enum logic [1:0] {
      OP_RING_WR = 2'd0,
      OP_RING_RD = 2'd1,
      OP_WORD_RD = 2'd2,
      OP_WORD_WR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_RING_ERR = 2'd1,
      STAT_ADDR_ERR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_RING_START = 2'd0,
      REG_RING_SIZE  = 2'd1,
      REG_BIG_ENDIAN = 2'd2
   } reg_index_type;

   localparam logic [OFF_W-1:0]  RST_RING_START = '0;
   localparam logic [SIZE_W-1:0] RST_RING_SIZE  = 13'd4096;
   localparam logic              RST_BIG_ENDIAN = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [OFF_W-1:0]  ring_start;
      logic [SIZE_W-1:0] ring_size;
      logic              big_endian;
   } cfg_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic fetch;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

/* sv/rbwp_csr.sv */
`default_nettype none
module rbwp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rbwp_pkg::PADDR_W-1:0]      paddr,
   input  wire logic [rbwp_pkg::PDATA_W-1:0]      pwdata,
   output logic      [rbwp_pkg::PDATA_W-1:0]      prdata,
   output logic                                   pready,
   output rbwp_pkg::cfg_type                      cfg
);

   rbwp_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rbwp_pkg::REG_RING_START: cfg_in.ring_start = pwdata[rbwp_pkg::OFF_W-1:0];
            rbwp_pkg::REG_RING_SIZE:  cfg_in.ring_size  = pwdata[rbwp_pkg::SIZE_W-1:0];
            rbwp_pkg::REG_BIG_ENDIAN: cfg_in.big_endian = pwdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rbwp_pkg::REG_RING_START:
            prdata = {{(rbwp_pkg::PDATA_W-rbwp_pkg::OFF_W){1'b0}}, cfg_ff.ring_start};
         rbwp_pkg::REG_RING_SIZE:
            prdata = {{(rbwp_pkg::PDATA_W-rbwp_pkg::SIZE_W){1'b0}}, cfg_ff.ring_size};
         rbwp_pkg::REG_BIG_ENDIAN:
            prdata = {{(rbwp_pkg::PDATA_W-1){1'b0}}, cfg_ff.big_endian};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_start <= rbwp_pkg::RST_RING_START;
         cfg_ff.ring_size  <= rbwp_pkg::RST_RING_SIZE;
         cfg_ff.big_endian <= rbwp_pkg::RST_BIG_ENDIAN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* sv/rbwp_ram.sv */
`default_nettype none
module rbwp_ram #(
   parameter int unsigned MEM_WORDS = rbwp_pkg::DEF_MEM_WORDS,
   parameter int unsigned AW        = $clog2(MEM_WORDS)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [31:0]   wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [31:0]   rdata
);

   logic [31:0] mem_ff [MEM_WORDS];
   logic [31:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

/* sv/rbwp_ctrl.sv */
`default_nettype none
module rbwp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rbwp_pkg::sts_type sts,
   output rbwp_pkg::cmd_type      cmd
);

   rbwp_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbwp_pkg::ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = rbwp_pkg::ST_IDLE;
            end
         end
         rbwp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rbwp_pkg::ST_DECIDE;
            end
         end
         rbwp_pkg::ST_DECIDE: begin
            state_in = rbwp_pkg::ST_EXEC;
         end
         rbwp_pkg::ST_EXEC: begin
            if (sts.out_free) begin
               state_in = rbwp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbwp_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         rbwp_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         rbwp_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         rbwp_pkg::ST_DECIDE: begin
            cmd.fetch = 1'b1;
         end
         rbwp_pkg::ST_EXEC: begin
            cmd.exec = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbwp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* sv/rbwp_dp.sv */
`default_nettype none
module rbwp_dp #(
   parameter int unsigned MEM_WORDS = rbwp_pkg::DEF_MEM_WORDS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rbwp_pkg::cmd_type             cmd,
   output rbwp_pkg::sts_type                  sts,
   input  wire rbwp_pkg::cfg_type             cfg,
   input  wire logic [1:0]                    req_operation,
   input  wire logic                          req_burst_first,
   input  wire logic                          req_burst_last,
   input  wire logic [rbwp_pkg::OFF_W-1:0]    req_offset,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic signed [31:0]            req_word_value,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic      [7:0]                    rsp_read_byte,
   output logic signed [31:0]                 rsp_word_data,
   output logic      [rbwp_pkg::OFF_W-1:0]    rsp_next_offset,
   output logic      [1:0]                    rsp_status,
   output logic                               rsp_done_res
);

   localparam int unsigned AW        = $clog2(MEM_WORDS);
   localparam int unsigned MEM_BYTES = MEM_WORDS * 4;
   localparam int unsigned OW        = rbwp_pkg::OFF_W;
   localparam int unsigned SW        = rbwp_pkg::SIZE_W;

   // Captured word.
   rbwp_pkg::op_type   op_ff;
   logic               first_ff;
   logic               last_ff;
   logic [OW-1:0]      off_ff;
   logic [7:0]         db_ff;
   logic [31:0]        wv_ff;

   // Burst state.
   logic [OW-1:0]      pos_ff, pos_in;
   logic               burst_ok_ff, burst_ok_in;
   logic [31:0]        pack_ff, pack_in;
   logic               fetched_ff;
   logic [AW-1:0]      clr_cnt_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [7:0]         rbyte_ff, rbyte_in;
   logic [31:0]        wdata_ff, wdata_in;
   logic [OW-1:0]      next_ff, next_in;
   logic [1:0]         status_ff, status_in;
   logic               done_ff, done_in;

   logic               setup_ok;
   logic               is_word;
   logic [OW-1:0]      pos_eff;
   logic               ok_eff;
   logic               ring_err;
   logic               word_ok;
   logic [1:0]         lane;
   logic [1:0]         byte_lane;
   logic [OW-2:0]      ring_idx_wide;
   logic [AW-1:0]      ring_idx;
   logic [AW-1:0]      word_idx;
   logic               need_fetch;
   logic [31:0]        pw0;
   logic [31:0]        pw1;
   logic [7:0]         byte_sel;
   logic [SW-1:0]      pos_inc;
   logic [OW-1:0]      pos_nxt;
   logic               wr_ring;
   logic               wr_word;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [31:0]        ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [31:0]        ram_rdata;

   assign setup_ok = (cfg.ring_start[1:0] == 2'b00) &&
                     (32'(cfg.ring_start) < MEM_BYTES) &&
                     (cfg.ring_size != '0) &&
                     (cfg.ring_size[1:0] == 2'b00) &&
                     (32'(cfg.ring_size) <= MEM_BYTES) &&
                     ((32'(cfg.ring_start) + 32'(cfg.ring_size)) <= MEM_BYTES);

   assign is_word  = op_ff[1];
   assign pos_eff  = first_ff ? off_ff : pos_ff;
   assign ok_eff   = first_ff ? (setup_ok && ({1'b0, off_ff} < cfg.ring_size)) : burst_ok_ff;
   assign ring_err = !(ok_eff && setup_ok && ({1'b0, pos_eff} < cfg.ring_size));
   assign word_ok  = (off_ff[1:0] == 2'b00) && ((32'(off_ff) + 32'd3) < MEM_BYTES);

   assign lane          = pos_eff[1:0];
   assign byte_lane     = cfg.big_endian ? ~lane : lane;
   assign ring_idx_wide = {1'b0, cfg.ring_start[OW-1:2]} + {1'b0, pos_eff[OW-1:2]};
   assign ring_idx      = AW'(ring_idx_wide);
   assign word_idx      = AW'(off_ff[OW-1:2]);

   // The start word of a burst, a new word of a read burst, and a word read need a fetch.
   always_comb begin
      if (is_word) begin
         need_fetch = (op_ff == rbwp_pkg::OP_WORD_RD) && word_ok;
      end else begin
         need_fetch = !ring_err &&
                      (first_ff || ((op_ff == rbwp_pkg::OP_RING_RD) && (lane == 2'd0)));
      end
   end

   assign pw0      = fetched_ff ? ram_rdata : pack_ff;
   assign byte_sel = pw0[{byte_lane, 3'b000} +: 8];

   always_comb begin
      pw1 = pw0;
      pw1[{byte_lane, 3'b000} +: 8] = db_ff;
   end

   assign pos_inc = {1'b0, pos_eff} + SW'(1);
   assign pos_nxt = (pos_inc >= cfg.ring_size) ? '0 : pos_inc[OW-1:0];

   // A complete word is stored at its last lane; the final byte stores a partial word.
   assign wr_ring = !is_word && (op_ff == rbwp_pkg::OP_RING_WR) && !ring_err &&
                    ((lane == 2'd3) || (last_ff && (pos_nxt[1:0] != 2'b00)));
   assign wr_word = (op_ff == rbwp_pkg::OP_WORD_WR) && word_ok;

   assign ram_we    = cmd.clear_en || (cmd.exec && (wr_ring || wr_word));
   assign ram_waddr = cmd.clear_en ? clr_cnt_ff : (is_word ? word_idx : ring_idx);
   assign ram_wdata = cmd.clear_en ? 32'd0 : (is_word ? wv_ff : pw1);
   assign ram_re    = cmd.fetch && need_fetch;
   assign ram_raddr = is_word ? word_idx : ring_idx;

   rbwp_ram #(
      .MEM_WORDS (MEM_WORDS),
      .AW        (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      pos_in      = pos_ff;
      burst_ok_in = burst_ok_ff;
      pack_in     = pack_ff;
      if (cmd.exec && !is_word) begin
         if (ring_err) begin
            pos_in      = pos_eff;
            burst_ok_in = 1'b0;
         end else begin
            pos_in      = pos_nxt;
            burst_ok_in = !last_ff;
            if (op_ff == rbwp_pkg::OP_RING_RD) begin
               pack_in = pw0;
            end else if (lane == 2'd3) begin
               pack_in = '0;
            end else begin
               pack_in = pw1;
            end
         end
      end
   end

   always_comb begin
      rbyte_in  = '0;
      wdata_in  = '0;
      next_in   = '0;
      status_in = rbwp_pkg::STAT_OK;
      done_in   = 1'b1;
      if (is_word) begin
         if (!word_ok) begin
            status_in = rbwp_pkg::STAT_ADDR_ERR;
         end else if (op_ff == rbwp_pkg::OP_WORD_RD) begin
            wdata_in = ram_rdata;
         end
      end else begin
         done_in = last_ff;
         if (ring_err) begin
            status_in = rbwp_pkg::STAT_RING_ERR;
            next_in   = pos_eff;
         end else begin
            next_in = pos_nxt;
            if (op_ff == rbwp_pkg::OP_RING_RD) begin
               rbyte_in = byte_sel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= rbwp_pkg::op_type'(req_operation);
         first_ff <= req_burst_first;
         last_ff  <= req_burst_last;
         off_ff   <= req_offset;
         db_ff    <= req_data_byte;
         wv_ff    <= req_word_value;
      end
      if (cmd.exec) begin
         rbyte_ff  <= rbyte_in;
         wdata_ff  <= wdata_in;
         next_ff   <= next_in;
         status_ff <= status_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         burst_ok_ff  <= 1'b0;
         pack_ff      <= '0;
         fetched_ff   <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         burst_ok_ff <= burst_ok_in;
         pack_ff     <= pack_in;
         if (cmd.fetch) begin
            fetched_ff <= need_fetch;
         end
         if (cmd.clear_en) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clear_last = (clr_cnt_ff == AW'(MEM_WORDS - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_byte   = rbyte_ff;
   assign rsp_word_data   = wdata_ff;
   assign rsp_next_offset = next_ff;
   assign rsp_status      = status_ff;
   assign rsp_done_res    = done_ff;

   a_no_write_on_fetch : assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> !ram_we)
      else $error("word RAM written in the fetch cycle");

   a_err_drops_burst : assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !is_word && ring_err) |=> !burst_ok_ff)
      else $error("ring error left the burst open");

   a_word_op_keeps_ring : assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && is_word) |=> ($stable(pos_ff) && $stable(burst_ok_ff) && $stable(pack_ff)))
      else $error("word operation changed the burst state");

   a_pos_inside_ring : assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !is_word && !ring_err) |=> ({1'b0, pos_ff} < cfg.ring_size))
      else $error("ring position left the ring");

   a_clear_is_exclusive : assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> (!cmd.capture && !cmd.fetch && !cmd.exec))
      else $error("item handled during the memory clear");

endmodule
`default_nettype wire

/* sv/ring_byte_word_packer.sv */
// A request word is accepted in the idle state, the RAM is read in the decide state,
// and the result word is registered in execute once the output register is free.
// No new request word is taken until the last one is executed: the controller steps
// through accept, fetch and execute around the single read port of the word RAM.
// Reset is synchronous and active high; it clears the control, burst and configuration state,
// then a clearing pass zeroes every RAM word while req_stall stays high.
`default_nettype none
module ring_byte_word_packer #(
   parameter int unsigned MEM_WORDS = rbwp_pkg::DEF_MEM_WORDS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic                          req_burst_first,
   input  wire logic                          req_burst_last,
   input  wire logic [rbwp_pkg::OFF_W-1:0]    req_offset,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic signed [31:0]            req_word_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [7:0]                    rsp_read_byte,
   output logic signed [31:0]                 rsp_word_data,
   output logic      [rbwp_pkg::OFF_W-1:0]    rsp_next_offset,
   output logic      [1:0]                    rsp_status,
   output logic                               rsp_done_res,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rbwp_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [rbwp_pkg::PDATA_W-1:0]  pwdata,
   output logic      [rbwp_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready
);

   rbwp_pkg::cfg_type cfg;
   rbwp_pkg::cmd_type cmd;
   rbwp_pkg::sts_type sts;

   rbwp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rbwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbwp_dp #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .cfg             (cfg),
      .req_operation   (req_operation),
      .req_burst_first (req_burst_first),
      .req_burst_last  (req_burst_last),
      .req_offset      (req_offset),
      .req_data_byte   (req_data_byte),
      .req_word_value  (req_word_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_word_data   (rsp_word_data),
      .rsp_next_offset (rsp_next_offset),
      .rsp_status      (rsp_status),
      .rsp_done_res    (rsp_done_res)
   );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;

   localparam int unsigned MEM_BYTES  = rbwp_pkg::DEF_MEM_WORDS * 4;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD  = 400;

   typedef struct packed {
      logic [7:0]                 read_byte;
      logic [31:0]                word_data;
      logic [rbwp_pkg::OFF_W-1:0] next_offset;
      logic [1:0]                 status;
      logic                       done_res;
   } rsp_word_type;

   class ring_packer_scoreboard;
      bit [31:0]    mem [rbwp_pkg::DEF_MEM_WORDS];
      bit [11:0]    ring_start;
      bit [12:0]    ring_size;
      bit           big_endian;
      int unsigned  ring_pos;
      bit [31:0]    packing_word;
      bit           burst_ok;
      rsp_word_type expected_words[$];
      int unsigned  errors;

      function new();
         foreach (mem[i]) mem[i] = '0;
         ring_start = rbwp_pkg::RST_RING_START;
         ring_size = rbwp_pkg::RST_RING_SIZE;
         big_endian = rbwp_pkg::RST_BIG_ENDIAN;
         ring_pos = 0;
         packing_word = '0;
         burst_ok = 1'b0;
         errors = 0;
      endfunction

      function void set_register(rbwp_pkg::reg_index_type idx, bit [31:0] v);
         case (idx)
            rbwp_pkg::REG_RING_START: ring_start = v[11:0];
            rbwp_pkg::REG_RING_SIZE:  ring_size = v[12:0];
            rbwp_pkg::REG_BIG_ENDIAN: big_endian = v[0];
            default: ;
         endcase
      endfunction

      function bit [31:0] register_value(rbwp_pkg::reg_index_type idx);
         case (idx)
            rbwp_pkg::REG_RING_START: return {20'd0, ring_start};
            rbwp_pkg::REG_RING_SIZE:  return {19'd0, ring_size};
            rbwp_pkg::REG_BIG_ENDIAN: return {31'd0, big_endian};
            default:                  return '0;
         endcase
      endfunction

      function bit setup_valid();
         int unsigned s;
         int unsigned z;
         s = {20'd0, ring_start};
         z = {19'd0, ring_size};
         return (s % 4 == 0) && (s < MEM_BYTES) && (z > 0) && (z % 4 == 0) &&
                (z <= MEM_BYTES) && (s + z <= MEM_BYTES);
      endfunction

      function int unsigned word_of(int unsigned pos);
         return {20'd0, ring_start} / 4 + pos / 4;
      endfunction

      function bit [31:0] load(int unsigned idx);
         return (idx < rbwp_pkg::DEF_MEM_WORDS) ? mem[idx] : 32'd0;
      endfunction

      function void store(int unsigned idx, bit [31:0] v);
         if (idx < rbwp_pkg::DEF_MEM_WORDS) mem[idx] = v;
      endfunction

      function bit count_error();
         errors++;
         return errors <= 10;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void predict_word(rbwp_pkg::op_type op, bit is_first, bit is_last,
                                 bit [11:0] off, bit [7:0] db, bit [31:0] wv);
         rsp_word_type r;
         int unsigned  j;
         int unsigned  lane;
         int unsigned  sh;
         int unsigned  size32;
         r = '0;
         r.done_res = 1'b1;
         r.status = rbwp_pkg::STAT_OK;
         size32 = {19'd0, ring_size};
         if (op == rbwp_pkg::OP_WORD_RD || op == rbwp_pkg::OP_WORD_WR) begin
            if (off[1:0] == 2'b00 && {20'd0, off} + 3 < MEM_BYTES) begin
               if (op == rbwp_pkg::OP_WORD_RD) r.word_data = load({22'd0, off[11:2]});
               else store({22'd0, off[11:2]}, wv);
            end else begin
               r.status = rbwp_pkg::STAT_ADDR_ERR;
            end
         end else begin
            if (is_first) begin
               ring_pos = {20'd0, off};
               burst_ok = setup_valid() && ring_pos < size32;
               if (burst_ok) packing_word = load(word_of(ring_pos));
            end
            if (!(burst_ok && setup_valid() && ring_pos < size32)) begin
               r.status = rbwp_pkg::STAT_RING_ERR;
               r.next_offset = 12'(ring_pos);
               burst_ok = 1'b0;
            end else begin
               j = ring_pos;
               lane = j % 4;
               sh = big_endian ? 24 - 8 * lane : 8 * lane;
               if (op == rbwp_pkg::OP_RING_RD) begin
                  if (!is_first && lane == 0) packing_word = load(word_of(j));
                  r.read_byte = 8'(packing_word >> sh);
               end else begin
                  packing_word = (packing_word & ~(32'hFF << sh)) | ({24'd0, db} << sh);
                  if (lane == 3) begin
                     store(word_of(j), packing_word);
                     packing_word = '0;
                  end
               end
               j++;
               if (j >= size32) j = 0;
               // A burst ending inside a word still commits the partial word.
               if (op == rbwp_pkg::OP_RING_WR && is_last && j % 4 != 0)
                  store(word_of(j), packing_word);
               ring_pos = j;
               r.next_offset = 12'(j);
            end
            r.done_res = is_last;
            if (is_last) burst_ok = 1'b0;
         end
         expected_words.push_back(r);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            if (count_error())
               $display("unexpected result word: byte %h word %h next %h status %0d done %0d",
                        got.read_byte, got.word_data, got.next_offset, got.status,
                        got.done_res);
            return;
         end
         want = expected_words.pop_front();
         if (got !== want && count_error())
            $display({"result mismatch: expected byte %h word %h next %h status %0d done %0d,",
                      " got byte %h word %h next %h status %0d done %0d"},
                     want.read_byte, want.word_data, want.next_offset, want.status,
                     want.done_res, got.read_byte, got.word_data, got.next_offset,
                     got.status, got.done_res);
      endfunction

      function void check_register(rbwp_pkg::reg_index_type idx, bit [31:0] got);
         if (got !== register_value(idx) && count_error())
            $display("register %0d readback: expected %h, got %h", idx,
                     register_value(idx), got);
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [1:0]                       req_operation;
   logic                             req_burst_first;
   logic                             req_burst_last;
   logic [rbwp_pkg::OFF_W-1:0]       req_offset;
   logic [7:0]                       req_data_byte;
   logic signed [31:0]               req_word_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [7:0]                       rsp_read_byte;
   logic signed [31:0]               rsp_word_data;
   logic [rbwp_pkg::OFF_W-1:0]       rsp_next_offset;
   logic [1:0]                       rsp_status;
   logic                             rsp_done_res;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [rbwp_pkg::PADDR_W-1:0]     paddr;
   logic [rbwp_pkg::PDATA_W-1:0]     pwdata;
   logic [rbwp_pkg::PDATA_W-1:0]     prdata;
   logic                             pready;

   ring_packer_scoreboard sb = new();
   bit          calm;
   bit          long_hold;
   int unsigned hold_count;
   int unsigned cycle_count;

   ring_byte_word_packer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_burst_first(req_burst_first),
      .req_burst_last (req_burst_last),
      .req_offset     (req_offset),
      .req_data_byte  (req_data_byte),
      .req_word_value (req_word_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_word_data  (rsp_word_data),
      .rsp_next_offset(rsp_next_offset),
      .rsp_status     (rsp_status),
      .rsp_done_res   (rsp_done_res),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // The receiver holds off once for a long stretch so that the block fills up.
   initial begin
      hold_count = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && hold_count < LONG_HOLD) begin
            rsp_stall = 1'b1;
            hold_count++;
         end else if (calm) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(99) < 29);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word({rsp_read_byte, rsp_word_data, rsp_next_offset, rsp_status,
                        rsp_done_res});
   end

   task automatic send_word(input rbwp_pkg::op_type op, input bit is_first,
                            input bit is_last, input bit [11:0] off, input bit [7:0] db,
                            input bit [31:0] wv);
      if (!calm)
         while ($urandom_range(99) < 29) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      req_operation = op;
      req_burst_first = is_first;
      req_burst_last = is_last;
      req_offset = off;
      req_data_byte = db;
      req_word_value = wv;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.predict_word(op, is_first, is_last, off, db, wv);
      @(negedge clock);
   endtask

   task automatic csr_write(input rbwp_pkg::reg_index_type idx, input bit [31:0] v);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, v);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_read_check(input rbwp_pkg::reg_index_type idx);
      bit [31:0] got;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      sb.check_register(idx, got);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic configure(input bit [11:0] start, input bit [12:0] size, input bit big);
      csr_write(rbwp_pkg::REG_RING_START, {20'd0, start});
      csr_write(rbwp_pkg::REG_RING_SIZE, {19'd0, size});
      csr_write(rbwp_pkg::REG_BIG_ENDIAN, {31'd0, big});
      csr_read_check(rbwp_pkg::REG_RING_START);
      csr_read_check(rbwp_pkg::REG_RING_SIZE);
      csr_read_check(rbwp_pkg::REG_BIG_ENDIAN);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_word_op();
      bit [11:0]   off;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50 && sb.setup_valid())
         off = 12'({20'd0, sb.ring_start} +
                   4 * $urandom_range({19'd0, sb.ring_size} / 4 - 1));
      else if (pick < 85)
         off = {10'($urandom_range(1023)), 2'b00};
      else
         off = 12'($urandom);
      send_word(($urandom_range(1) == 1) ? rbwp_pkg::OP_WORD_WR : rbwp_pkg::OP_WORD_RD,
                1'($urandom), 1'($urandom), off, 8'($urandom), $urandom);
   endtask

   task automatic send_burst(input rbwp_pkg::op_type op, input int len);
      bit [11:0]        start;
      int unsigned      size32;
      rbwp_pkg::op_type item_op;
      size32 = {19'd0, sb.ring_size};
      if (size32 != 0 && size32 <= MEM_BYTES && $urandom_range(9) != 0)
         start = 12'($urandom_range(size32 - 1));
      else
         start = 12'($urandom);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) send_word_op();
         item_op = op;
         if ($urandom_range(19) == 0)
            item_op = (op == rbwp_pkg::OP_RING_WR) ? rbwp_pkg::OP_RING_RD :
                                                      rbwp_pkg::OP_RING_WR;
         send_word(item_op, i == 0, i == len - 1, (i == 0) ? start : 12'($urandom),
                   8'($urandom), $urandom);
      end
   endtask

   task automatic random_traffic(input int n);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            if ($urandom_range(9) == 0) len = $urandom_range(40, 13);
            else len = $urandom_range(12, 1);
            send_burst(($urandom_range(1) == 1) ? rbwp_pkg::OP_RING_WR :
                                                  rbwp_pkg::OP_RING_RD, len);
            sent += len;
         end else if (kind < 85) begin
            send_word_op();
            sent++;
         end else begin
            send_word(($urandom_range(1) == 1) ? rbwp_pkg::OP_RING_WR : rbwp_pkg::OP_RING_RD,
                      1'($urandom), 1'($urandom), 12'($urandom), 8'($urandom), $urandom);
            sent++;
         end
      end
   endtask

   task automatic directed_words();
      send_word(rbwp_pkg::OP_WORD_WR, 1'b0, 1'b0, 12'd0, 8'h00, 32'h8000_0000);
      send_word(rbwp_pkg::OP_WORD_WR, 1'b1, 1'b1, 12'd4092, 8'hFF, 32'hFFFF_FFFF);
      send_word(rbwp_pkg::OP_WORD_WR, 1'b0, 1'b0, 12'd4, 8'h00, 32'h7FFF_FFFF);
      send_word(rbwp_pkg::OP_WORD_RD, 1'b0, 1'b0, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_WORD_RD, 1'b0, 1'b0, 12'd4092, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_WORD_RD, 1'b0, 1'b0, 12'd4095, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_WORD_WR, 1'b0, 1'b0, 12'd2, 8'h00, 32'h1234_5678);
      send_word(rbwp_pkg::OP_WORD_RD, 1'b0, 1'b0, 12'd0, 8'h00, 32'h0);
      // Continuation words without a burst start must be rejected.
      send_word(rbwp_pkg::OP_RING_RD, 1'b0, 1'b0, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_WR, 1'b0, 1'b1, 12'd0, 8'h11, 32'h0);
      send_word(rbwp_pkg::OP_RING_WR, 1'b1, 1'b0, 12'd4094, 8'hFF, 32'h0);
      send_word(rbwp_pkg::OP_RING_WR, 1'b0, 1'b0, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_WR, 1'b0, 1'b0, 12'd0, 8'hA5, 32'h0);
      send_word(rbwp_pkg::OP_RING_WR, 1'b0, 1'b1, 12'd0, 8'h5A, 32'h0);
      send_word(rbwp_pkg::OP_RING_RD, 1'b1, 1'b0, 12'd4094, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_RD, 1'b0, 1'b0, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_RD, 1'b0, 1'b0, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_RD, 1'b0, 1'b1, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_WR, 1'b1, 1'b1, 12'd5, 8'h3C, 32'h0);
      send_word(rbwp_pkg::OP_WORD_RD, 1'b0, 1'b0, 12'd4, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_RING_RD, 1'b1, 1'b0, 12'd6, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_WORD_WR, 1'b0, 1'b1, 12'd8, 8'h00, 32'hCAFE_0F0F);
      send_word(rbwp_pkg::OP_RING_WR, 1'b0, 1'b0, 12'd0, 8'h77, 32'h0);
      send_word(rbwp_pkg::OP_RING_RD, 1'b0, 1'b1, 12'd0, 8'h00, 32'h0);
      send_word(rbwp_pkg::OP_WORD_RD, 1'b0, 1'b0, 12'd4, 8'h00, 32'h0);
   endtask

   initial begin
      bit [11:0] starts [11];
      bit [12:0] sizes [11];
      bit        bigs [11];
      int        counts [11];
      starts = '{12'd0, 12'd4092, 12'd0, 12'd1024, 12'd8, 12'd6, 12'd100, 12'd2048,
                 12'd4095, 12'd512, 12'd3000};
      sizes = '{13'd4096, 13'd4, 13'd4096, 13'd64, 13'd0, 13'd16, 13'd18, 13'd2052,
                13'd8191, 13'd12, 13'd1096};
      bigs = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
      counts = '{170, 190, 190, 190, 40, 40, 40, 40, 40, 190, 190};
      calm = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = rbwp_pkg::OP_RING_WR;
      req_burst_first = 1'b0;
      req_burst_last = 1'b0;
      req_offset = '0;
      req_data_byte = '0;
      req_word_value = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int p = 0; p < 11; p++) begin
         configure(starts[p], sizes[p], bigs[p]);
         calm = (p == 2);
         if (p == 3) long_hold = 1'b1;
         if (p == 0) directed_words();
         if (p == 9) begin
            random_traffic(counts[p] / 2);
            drain();
            random_traffic(counts[p] / 2);
         end else begin
            random_traffic(counts[p]);
         end
         drain();
      end
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
sv/rbwp_pkg.sv
sv/rbwp_csr.sv
sv/rbwp_ram.sv
sv/rbwp_ctrl.sv
sv/rbwp_dp.sv
sv/ring_byte_word_packer.sv
tb/tb_top.sv
